// ===== hdl/bsfr_pkg.sv =====
`timescale 1ns / 1ps

package bsfr_pkg;

    // Default packet length in bytes (legal range 1 to 64)
    localparam int PACKET_BYTES_DEF = 32;

    // Byte-stuffing codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Width of the byte_index result field
    localparam int INDEX_W = 6;

    // Write-side control from the front end to the packet buffer
    typedef struct packed {
        logic wr_en;   // store one unescaped byte
        logic commit;  // this byte completes the packet in the current bank
        logic bank;    // bank being filled
    } bsfr_wr_ctrl_t;

endpackage

// ===== hdl/bsfr_front.sv =====
`timescale 1ns / 1ps

module bsfr_front #(
    parameter int PACKET_BYTES = bsfr_pkg::PACKET_BYTES_DEF,
    parameter int IDX_W        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  logic                   bank_full,
    output bsfr_pkg::bsfr_wr_ctrl_t wr_ctrl,
    output logic [IDX_W-1:0]       wr_idx,
    output logic [7:0]             wr_data
);
    import bsfr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic             store;
    logic             commit;
    logic [7:0]       store_data;

    // Input is held off only while both packet banks wait for the back end
    assign in_ready = ~bank_full;
    assign accept   = in_valid & ~bank_full;

    // Deframing: classify the received byte and update the frame state
    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        bank_next     = bank_reg;
        store         = 1'b0;
        commit        = 1'b0;
        store_data    = rx_byte;

        if (accept)
        begin
            if (esc_reg)
            begin
                // escaped byte: never a flag
                esc_next   = 1'b0;
                store      = 1'b1;
                store_data = rx_byte ^ ESC_XOR;
            end
            else if (rx_byte == FLAG_BYTE)
            begin
                // flag opens a frame, dropping any partial one
                in_frame_next = 1'b1;
                count_next    = '0;
            end
            else if (in_frame_reg)
            begin
                if (rx_byte == ESC_BYTE)
                    esc_next = 1'b1;
                else
                    store = 1'b1;
            end
        end

        if (store)
        begin
            if (count_reg == LAST_IDX)
            begin
                // packet complete: hand the bank over, leave the frame
                commit        = 1'b1;
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                count_next    = '0;
                bank_next     = ~bank_reg;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            bank_reg     <= bank_next;
        end
    end

    assign wr_ctrl.wr_en  = store;
    assign wr_ctrl.commit = commit;
    assign wr_ctrl.bank   = bank_reg;
    assign wr_idx         = count_reg;
    assign wr_data        = store_data;

endmodule

// ===== hdl/bsfr_back.sv =====
`timescale 1ns / 1ps

module bsfr_back #(
    parameter int PACKET_BYTES = bsfr_pkg::PACKET_BYTES_DEF,
    parameter int IDX_W        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsfr_pkg::bsfr_wr_ctrl_t      wr_ctrl,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [7:0]                   wr_data,
    output logic                         bank_full,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   data_byte,
    output logic [bsfr_pkg::INDEX_W-1:0] byte_index,
    output logic                         last
);
    import bsfr_pkg::*;

    localparam int               DEPTH    = 2 * (1 << IDX_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       level_reg, level_next;   // banks holding a complete packet
    logic             rd_bank_reg, rd_bank_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             release_bank;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [0:DEPTH-1];

    // Two-bank packet buffer: the front fills one bank while the other drains
    always_ff @(posedge clk)
    begin
        if (wr_ctrl.wr_en)
            mem[{wr_ctrl.bank, wr_idx}] <= wr_data;
        if (state_reg == ST_FETCH)
            rd_data_reg <= mem[{rd_bank_reg, idx_reg}];
    end

    // Read sequencer: fetch one byte, show it until taken, next byte
    always_comb
    begin
        state_next   = state_reg;
        rd_bank_next = rd_bank_reg;
        idx_next     = idx_reg;
        release_bank = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (level_reg != 2'd0)
                begin
                    idx_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        release_bank = 1'b1;
                        rd_bank_next = ~rd_bank_reg;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        level_next = level_reg + {1'b0, wr_ctrl.commit} - {1'b0, release_bank};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            level_reg   <= 2'd0;
            rd_bank_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            rd_bank_reg <= rd_bank_next;
            idx_reg     <= idx_next;
        end
    end

    assign bank_full  = (level_reg == 2'd2);
    assign out_valid  = (state_reg == ST_SHOW);
    assign data_byte  = rd_data_reg;
    assign byte_index = INDEX_W'(idx_reg);
    assign last       = (idx_reg == LAST_IDX);

endmodule

// ===== hdl/byte_stuffed_frame_receiver.sv =====
`timescale 1ns / 1ps

// Byte-stuffed frame receiver.
// Input channel (in_valid/in_ready, rx_byte): one raw serial byte per
// transaction. 0x7E opens a frame and restarts it; 0x7D escapes the next
// byte, which is stored XOR 0x20. Bytes outside a frame are dropped.
// Output channel (out_valid/out_ready): once PACKET_BYTES bytes are stored,
// the packet is sent as PACKET_BYTES transactions of data_byte, byte_index
// and last (set on the final byte).
// Throughput: the front end takes one byte per cycle while a bank is free.
// Packets sit in a two-bank buffer; the back end reads each byte from
// memory (ST_FETCH), then shows it (ST_SHOW) until it is taken, and passes
// through ST_IDLE between packets. With the back end idle, out_valid rises
// once the commit has passed through the level count, ST_IDLE and ST_FETCH.
// When the receiver stalls, the output byte holds; once both banks hold
// unsent packets, in_ready drops until the back end frees a bank.
// Reset (rst_n, asynchronous) leaves the block out of frame with an empty
// buffer; no clearing pass is needed.
module byte_stuffed_frame_receiver #(
    parameter int PACKET_BYTES = bsfr_pkg::PACKET_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   data_byte,
    output logic [bsfr_pkg::INDEX_W-1:0] byte_index,
    output logic                         last
);
    import bsfr_pkg::*;

    localparam int IDX_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

    bsfr_wr_ctrl_t    wr_ctrl;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic             bank_full;

    bsfr_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .bank_full (bank_full),
        .wr_ctrl   (wr_ctrl),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data)
    );

    bsfr_back #(
        .PACKET_BYTES (PACKET_BYTES),
        .IDX_W        (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_ctrl    (wr_ctrl),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .bank_full  (bank_full),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .last       (last)
    );

    // A packet is never committed into a bank that is still waiting to drain
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_ctrl.commit && bank_full))
        else $error("packet committed while both banks full");

    // Buffer writes happen only on an accepted input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctrl.wr_en |-> (in_valid && in_ready))
        else $error("buffer write without input transaction");

    // After the last byte of a packet is taken, the output goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("output still valid after last byte");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import bsfr_pkg::*;

    localparam int PKT       = PACKET_BYTES_DEF;
    localparam int MAX_CYC   = 2000000;
    localparam int TAIL_CYC  = 24;
    localparam int RAND_SENT = 450;

    // One unescaped packet byte as the back end should send it
    typedef struct {
        logic [7:0]         data;
        logic [INDEX_W-1:0] idx;
        logic               fin;
    } pkt_byte_t;

    // Queued serial byte; a drain entry holds the sender until all packets are out
    typedef struct {
        logic [7:0] rx;
        bit         drain;
    } line_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last;

    line_byte_t line_q[$];
    pkt_byte_t  packet_q[$];

    // Shadow deframer state
    bit         sh_in_frame;
    bit         sh_escape;
    int         sh_count;
    logic [7:0] sh_store[PKT];

    int  n_sent;
    int  n_accepted;
    int  n_checked;
    int  n_packets;
    int  n_errors;
    int  cycle;
    bit  in_fire;

    // Sender burst control
    int  burst_left;
    int  gap_left;

    // Receiver stall pattern
    int  stall_mode;
    int  mode_left;

    always #4 clk = ~clk;

    byte_stuffed_frame_receiver #(
        .PACKET_BYTES(PKT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_byte (data_byte),
        .byte_index(byte_index),
        .last      (last)
    );

    // Predict the effect of one accepted line byte
    task automatic absorb_rx_byte(input logic [7:0] raw);
        logic [7:0] b;
        pkt_byte_t  pb;
        b = raw;
        if (sh_escape)
        begin
            sh_escape = 1'b0;
            b = b ^ ESC_XOR;
        end
        else
        begin
            if (b == FLAG_BYTE)
            begin
                sh_in_frame = 1'b1;
                sh_count = 0;
                return;
            end
            if (!sh_in_frame)
                return;
            if (b == ESC_BYTE)
            begin
                sh_escape = 1'b1;
                return;
            end
        end
        if (sh_count < PKT)
            sh_store[sh_count] = b;
        sh_count++;
        if (sh_count < PKT)
            return;
        for (int k = 0; k < PKT; k++)
        begin
            pb.data = sh_store[k];
            pb.idx  = k[INDEX_W-1:0];
            pb.fin  = (k == PKT - 1);
            packet_q.push_back(pb);
        end
        sh_in_frame = 1'b0;
        sh_escape = 1'b0;
        sh_count = 0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        line_byte_t lb;
        lb.rx = b;
        lb.drain = 1'b0;
        line_q.push_back(lb);
        n_sent++;
    endtask

    task automatic push_drain();
        line_byte_t lb;
        lb.rx = 8'h00;
        lb.drain = 1'b1;
        line_q.push_back(lb);
    endtask

    // Stuff one payload byte; ordinary bytes are sometimes escaped as well
    task automatic push_payload(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0)
        begin
            push_byte(ESC_BYTE);
            push_byte(b ^ ESC_XOR);
        end
        else
            push_byte(b);
    endtask

    function automatic logic [7:0] random_payload();
        case ($urandom_range(0, 9))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            2: return FLAG_BYTE ^ ESC_XOR;
            3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Input acceptance, prediction and result checking
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (packet_q.size() == 0)
            begin
                $error("unexpected packet byte: data_byte %h byte_index %0d last %b",
                       data_byte, byte_index, last);
                n_errors++;
            end
            else
            begin
                pkt_byte_t pb;
                pb = packet_q.pop_front();
                if (data_byte !== pb.data)
                begin
                    $error("data_byte: expected %h, got %h", pb.data, data_byte);
                    n_errors++;
                end
                if (byte_index !== pb.idx)
                begin
                    $error("byte_index: expected %0d, got %0d", pb.idx, byte_index);
                    n_errors++;
                end
                if (last !== pb.fin)
                begin
                    $error("last: expected %b, got %b", pb.fin, last);
                    n_errors++;
                end
                n_checked++;
                if (pb.fin)
                    n_packets++;
            end
        end
        if (in_fire)
        begin
            absorb_rx_byte(rx_byte);
            n_accepted++;
        end
    end

    // Sender: bursts with random gaps, plus drain holds
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
        begin
            // transaction still pending, hold valid and payload
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (line_q.size() > 0 && line_q[0].drain)
        begin
            if (packet_q.size() == 0)
                void'(line_q.pop_front());
            in_valid <= 1'b0;
        end
        else if (line_q.size() > 0)
        begin
            line_byte_t lb;
            lb = line_q.pop_front();
            in_valid <= 1'b1;
            rx_byte <= lb.rx;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
                gap_left = $urandom_range(1, 8);
            end
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: stall pattern switches between several modes
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (cycle % 3 == 0);
                default: out_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle++;
        if (cycle > MAX_CYC)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        bit drained;
        drained = 1'b0;

        // Directed: bytes outside a frame, including a stray escape
        push_byte(ESC_BYTE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ESC_BYTE);
        // Open a frame, then restart it mid-frame
        push_byte(FLAG_BYTE);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(FLAG_BYTE);
        // Full packet with field extremes and escape corner cases
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ESC_BYTE);
        push_byte(FLAG_BYTE ^ ESC_XOR);
        push_byte(ESC_BYTE);
        push_byte(FLAG_BYTE);        // flag after escape is data
        push_byte(ESC_BYTE);
        push_byte(ESC_BYTE);         // escape after escape
        for (int i = 5; i < PKT; i++)
            push_byte(8'h80 + i[7:0]);
        // Packet done: these are ignored
        push_byte(ESC_BYTE);
        push_byte(8'h41);
        push_drain();

        // Random: mostly well-formed frames, some aborted, some noise
        while (n_sent < RAND_SENT)
        begin
            int sel;
            sel = $urandom_range(0, 9);
            if (!drained && n_sent > RAND_SENT / 2)
            begin
                push_drain();
                drained = 1'b1;
            end
            if (sel == 0)
            begin
                int n;
                n = $urandom_range(0, PKT - 1);
                push_byte(FLAG_BYTE);
                for (int i = 0; i < n; i++)
                    push_payload(random_payload());
            end
            else
            begin
                push_byte(FLAG_BYTE);
                if (sel == 1)
                    push_byte(FLAG_BYTE);
                for (int i = 0; i < PKT; i++)
                    push_payload(random_payload());
                if (sel == 2)
                begin
                    int n;
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        push_byte($urandom_range(0, 1) ? ESC_BYTE
                                  : 8'($urandom_range(0, FLAG_BYTE - 1)));
                end
            end
        end

        // Reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every byte to be taken and every packet byte to arrive
        while (n_accepted < n_sent || line_q.size() != 0)
            @(negedge clk);
        while (packet_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYC) @(negedge clk);

        $display("Sent %0d line bytes; checked %0d packet bytes in %0d packets.",
                 n_accepted, n_checked, n_packets);
        $display("Covered escapes, flag restarts, out-of-frame bytes and receiver stalls.");
        if (n_errors == 0 && packet_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== byte_stuffed_frame_receiver.f =====
hdl/bsfr_pkg.sv
hdl/bsfr_front.sv
hdl/bsfr_back.sv
hdl/byte_stuffed_frame_receiver.sv
test/tb_top.sv
